@@ rtl/b2rd_pkg.sv @@
// Shared widths, constants, types and helpers of the binary to radix digit converter.
`timescale 1ns / 1ps

package b2rd_pkg;

   localparam int VALUE_W   = 63;
   localparam int RADIX_W   = 5;
   localparam int DIGIT_W   = 4;
   localparam int CHAR_W    = 7;

   // A 63-bit value has at most 63 digits at the smallest radix.
   localparam int NUM_CELLS   = VALUE_W;
   localparam int CONV_CYCLES = VALUE_W + NUM_CELLS - 1;
   localparam int CNT_W       = $clog2(CONV_CYCLES);
   localparam int POS_W       = $clog2(NUM_CELLS);

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

   localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 4'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
   localparam logic [CHAR_W-1:0]  CHAR_NINE   = 7'd57;
   localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = 7'd65;
   localparam logic [CHAR_W-1:0]  CHAR_TOP    = 7'd70;

   typedef struct packed {
      logic clear;
      logic step;
      logic retire;
      logic shift;
   } row_ctrl_type;

   function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] digit);
      logic [CHAR_W-1:0] result;
      if (digit < DEC_DIGITS) begin
         result = CHAR_ZERO + CHAR_W'(digit);
      end else begin
         result = CHAR_ALPHA + CHAR_W'(digit - DEC_DIGITS);
      end
      return result;
   endfunction

endpackage

@@ rtl/b2rd_ifs.sv @@
// Request, response and control register channels of the digit converter.
`timescale 1ns / 1ps

interface b2rd_req_if;
   import b2rd_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2rd_rsp_if;
   import b2rd_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink   (input valid, input digit_char, input last, output ready);
endinterface

interface b2rd_csr_if;
   import b2rd_pkg::*;
   logic               valid;
   logic               ready;
   logic [RADIX_W-1:0] radix;

   modport source (output valid, output radix, input ready);
   modport sink   (input valid, input radix, output ready);
endinterface

@@ rtl/b2rd_digit_row.sv @@
// Row of radix digit cells with skewed, registered carries; drains top digit first.
`timescale 1ns / 1ps

module b2rd_digit_row import b2rd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  row_ctrl_type       ctrl,
   input  logic               bit_in,
   input  logic [RADIX_W-1:0] radix,
   output logic [DIGIT_W-1:0] top_digit
);

   logic [DIGIT_W-1:0] digit_ff  [NUM_CELLS];
   logic [DIGIT_W-1:0] digit_in  [NUM_CELLS];
   logic [DIGIT_W-1:0] reduced   [NUM_CELLS];
   logic [DIGIT_W:0]   doubled   [NUM_CELLS];
   logic [NUM_CELLS-1:0] carry_ff, carry_in;
   logic [NUM_CELLS-1:0] act_ff, act_in;
   logic [NUM_CELLS-1:0] cin_vec;
   logic [NUM_CELLS-1:0] wrap;

   // Cell i takes the registered carry of cell i-1; cell 0 takes the value's top bit.
   assign cin_vec = {carry_ff[NUM_CELLS-2:0], bit_in};

   always_comb begin
      for (int i = 0; i < NUM_CELLS; i++) begin
         doubled[i] = {digit_ff[i], cin_vec[i]};
         wrap[i]    = (doubled[i] >= radix);
         reduced[i] = wrap[i] ? DIGIT_W'(doubled[i] - radix) : doubled[i][DIGIT_W-1:0];
      end
   end

   always_comb begin
      digit_in = digit_ff;
      carry_in = carry_ff;
      act_in   = act_ff;
      if (ctrl.clear) begin
         for (int i = 0; i < NUM_CELLS; i++) begin
            digit_in[i] = '0;
         end
         carry_in = '0;
         act_in   = '1;
      end else if (ctrl.step) begin
         for (int i = 0; i < NUM_CELLS; i++) begin
            if (act_ff[i]) begin
               digit_in[i] = reduced[i];
            end
            carry_in[i] = act_ff[i] & wrap[i];
         end
         // retire one cell per cycle once the lowest cell has seen every bit
         if (ctrl.retire) begin
            act_in = {act_ff[NUM_CELLS-2:0], 1'b0};
         end
      end else if (ctrl.shift) begin
         digit_in[0] = '0;
         for (int i = 1; i < NUM_CELLS; i++) begin
            digit_in[i] = digit_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
         act_ff   <= '0;
      end else begin
         carry_ff <= carry_in;
         act_ff   <= act_in;
      end
      digit_ff <= digit_in;
   end

   assign top_digit = digit_ff[NUM_CELLS-1];

endmodule

@@ rtl/binary_to_radix_digits_top.sv @@
// Top level of the binary to radix digit converter.
`timescale 1ns / 1ps

// Converts one 63-bit unsigned value per request into its digit string in the
// radix held by the control register (2 to 16, values outside saturate; reset 10).
// Characters come out most significant first as ASCII '0'-'9', 'A'-'F', without
// leading zeros; the final character has last set, and zero gives a single '0'.
// Each request is converted in a row of 63 digit cells that shifts the value
// in one bit per cycle with carries rippling one cell per cycle, then the row
// drains top digit first; a new request is taken only once the drain is done.
// The last character waits in the output register while the next request is
// already accepted. Radix writes are held off while a conversion runs; a write
// taken in the same cycle as a request applies to that request, and one taken
// while digits drain applies to the next request.
module binary_to_radix_digits_top import b2rd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   b2rd_req_if.sink   req_ch,
   b2rd_rsp_if.source rsp_ch,
   b2rd_csr_if.sink   csr_ch
);

   typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               seen_ff, seen_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] radix_eff;
   logic [DIGIT_W-1:0] top_digit;
   logic               advance;
   logic               emit;
   row_ctrl_type       row_ctrl;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         radix_ff <= csr_ch.radix;
      end
   end

   // hold off radix writes while the row is converting
   assign csr_ch.ready = (state_ff != ST_CONV);

   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         radix_eff = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         radix_eff = RADIX_MAX;
      end else begin
         radix_eff = radix_ff;
      end
   end

   b2rd_digit_row u_row (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (row_ctrl),
      .bit_in    (value_ff[VALUE_W-1]),
      .radix     (radix_eff),
      .top_digit (top_digit)
   );

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   // drop leading zeros, but always send the units digit
   assign emit = (state_ff == ST_EMIT) && advance &&
                 (seen_ff || (top_digit != '0) || (pos_ff == '0));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      seen_in      = seen_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      row_ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               value_in       = req_ch.value;
               cnt_in         = '0;
               row_ctrl.clear = 1'b1;
               state_in       = ST_CONV;
            end
         end
         ST_CONV: begin
            row_ctrl.step   = 1'b1;
            row_ctrl.retire = (cnt_ff >= CNT_W'(VALUE_W - 1));
            value_in        = value_ff << 1;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CONV_CYCLES - 1)) begin
               pos_in   = POS_W'(NUM_CELLS - 1);
               seen_in  = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (advance) begin
               row_ctrl.shift = 1'b1;
               pos_in         = pos_ff - 1'b1;
               if (emit) begin
                  seen_in      = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = to_ascii(top_digit);
                  rsp_last_in  = (pos_ff == '0);
               end
               if (pos_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff    <= value_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.digit_char = rsp_char_ff;
   assign rsp_ch.last       = rsp_last_ff;

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_CONV) && (cnt_ff == '0))
      else $error("accepted request did not start conversion");

   a_units_digit_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && advance && (pos_ff == '0))
      |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("units digit not sent as final character");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_char_ff >= CHAR_ZERO) && (rsp_char_ff <= CHAR_NINE)) ||
                       ((rsp_char_ff >= CHAR_ALPHA) && (rsp_char_ff <= CHAR_TOP)))
      else $error("response character outside digit set");

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> !emit && !row_ctrl.shift)
      else $error("row drained during conversion");

endmodule
